### rtl/efdx_pkg.sv
// ----------------------------------------------------------------------------
// efdx_pkg
// Shared types and constants of the escaped frame decoder with XOR check.
// ----------------------------------------------------------------------------
package efdx_pkg;

    // Line codes of the framing layer.
    localparam logic [7:0] FLAG_BYTE     = 8'h7E;
    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] ESC_FLAG_CODE = 8'h02;
    localparam logic [7:0] ESC_ESC_CODE  = 8'h01;

    // Fixed part of a frame: 16 header bytes, 6 further header bytes and the check byte.
    localparam int unsigned HEAD_BYTES = 23;
    localparam int unsigned HDR_KEEP   = 16;

    // Result kinds.
    localparam logic [1:0] KIND_OK   = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_OVF  = 2'd2;
    localparam logic [1:0] KIND_BODY = 2'd3;

    // Item commands.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Payload of one input beat.
    typedef struct packed {
        logic       func;
        logic [7:0] line_byte;
        logic [9:0] body_index;
    } t_in_beat;

    // Payload of one output beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] msg_id;
        logic [47:0] phone;
        logic [47:0] term_id;
        logic [9:0]  body_length;
        logic [7:0]  body_byte;
    } t_out_beat;

    // Result of the decoder before the store data joins it.
    typedef struct packed {
        logic        has_result;
        logic [1:0]  kind;
        logic [15:0] msg_id;
        logic [47:0] phone;
        logic [47:0] term_id;
        logic [9:0]  body_length;
    } t_res;

endpackage

### rtl/efdx_in_if.sv
// ----------------------------------------------------------------------------
// efdx_in_if
// Valid/ready channel that carries line bytes and body read requests.
// ----------------------------------------------------------------------------
interface efdx_in_if import efdx_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/efdx_out_if.sv
// ----------------------------------------------------------------------------
// efdx_out_if
// Valid/ready channel that carries frame reports and body bytes.
// ----------------------------------------------------------------------------
interface efdx_out_if import efdx_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/escaped_frame_decoder_xor_check_core.sv
// ----------------------------------------------------------------------------
// escaped_frame_decoder_xor_check_core
// Escaped frame decoder with XOR check: unescapes line bytes into a frame
// store, checks length and XOR at the closing flag, and reads body bytes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Beat contents
//  i_in    | input     | func, line_byte, body_index
//  o_out   | output    | kind, msg_id, phone, term_id, body_length, body_byte
//
//  One beat is accepted every cycle unless a stalled output holds both stages;
//  each beat takes one pass through the decoder and the single write or read
//  port of the frame store. A result passes through stage one, which waits for
//  the registered store read, and then through the output register.
//  Reset clears the framing state at once; the store needs no clearing pass.
//  A stalled output holds both stages; input ready falls only when both hold.
// ----------------------------------------------------------------------------
module escaped_frame_decoder_xor_check_core import efdx_pkg::*; #(
    parameter int unsigned BUFFER_DEPTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    efdx_in_if.sink     i_in,
    efdx_out_if.source  o_out
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    logic          accept;
    logic          out_take;
    logic          s1_move;
    t_res          res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic          r_s1_valid;
    t_res          r_s1;
    logic          r_out_valid;
    t_out_beat     r_out;
    t_out_beat     n_out;

    // Handshake of the two stages.
    assign out_take    = !r_out_valid || o_out.ready;
    assign s1_move     = r_s1_valid && out_take;
    assign i_in.ready  = !r_s1_valid || out_take;
    assign accept      = i_in.valid && i_in.ready;

    efdx_decoder #(
        .DEPTH (BUFFER_DEPTH)
    ) u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_beat    (i_in.data),
        .o_res     (res),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    efdx_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Stage one waits for the store read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= res.has_result;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= res;
        end
    end

    // Output beat assembly.
    always_comb begin
        n_out.kind        = r_s1.kind;
        n_out.msg_id      = r_s1.msg_id;
        n_out.phone       = r_s1.phone;
        n_out.term_id     = r_s1.term_id;
        n_out.body_length = r_s1.body_length;
        n_out.body_byte   = (r_s1.kind == KIND_BODY) ? rd_data : 8'h00;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

### rtl/efdx_ram.sv
// ----------------------------------------------------------------------------
// efdx_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module efdx_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/efdx_decoder.sv
// ----------------------------------------------------------------------------
// efdx_decoder
// Framing state, unescaping, running XOR, header capture and frame checks.
// Drives the write and read ports of the frame store.
// ----------------------------------------------------------------------------
module efdx_decoder import efdx_pkg::*; #(
    parameter int unsigned DEPTH = 2048,
    localparam int unsigned AW = $clog2(DEPTH),
    localparam int unsigned CW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  t_in_beat      i_beat,
    output t_res          o_res,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr
);

    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] COUNT_LAST = CW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_HEAD = CW'(HEAD_BYTES);
    localparam logic [CW-1:0] COUNT_KEEP = CW'(HDR_KEEP);
    localparam logic [AW-1:0] BODY_BASE  = AW'(HEAD_BYTES - 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_in_frame, n_in_frame;
    logic          r_esc, n_esc;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_hdr [HDR_KEEP];

    logic          byte_beat;
    logic [7:0]    c;
    logic [7:0]    v_byte;
    logic          do_store;
    logic          full;
    logic          wr_en;
    logic [CW-1:0] blen;
    logic [9:0]    hdr_len;
    logic          frame_ok;
    logic [47:0]   phone;
    logic [47:0]   term_id;

    assign byte_beat = i_accept && (i_beat.func == FUNC_BYTE);
    assign c         = i_beat.line_byte;
    assign full      = (r_count == COUNT_FULL);

    // Unescaped value of the current byte.
    always_comb begin
        v_byte = c;
        if (r_esc) begin
            if (c == ESC_FLAG_CODE) begin
                v_byte = FLAG_BYTE;
            end else if (c == ESC_ESC_CODE) begin
                v_byte = ESC_BYTE;
            end
        end
    end

    assign do_store = r_in_frame && (r_esc || ((c != ESC_BYTE) && (c != FLAG_BYTE)));
    assign wr_en    = byte_beat && do_store && !full;

    // Frame checks from the captured header and the running XOR.
    assign blen     = r_count - COUNT_HEAD;
    assign hdr_len  = {r_hdr[2][1:0], r_hdr[3]};
    assign frame_ok = (blen == CW'(hdr_len)) && (r_xor == 8'h00);

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            phone[47 - 8*k -: 8]   = r_hdr[4 + k];
            term_id[47 - 8*k -: 8] = r_hdr[10 + k];
        end
    end

    // Next state and result of one beat.
    always_comb begin
        n_count    = r_count;
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        n_xor      = r_xor;
        o_res      = '0;
        if (i_accept && (i_beat.func == FUNC_READ)) begin
            o_res.has_result = 1'b1;
            o_res.kind       = KIND_BODY;
        end else if (byte_beat) begin
            if (!r_in_frame) begin
                if (c == FLAG_BYTE) begin
                    n_in_frame = 1'b1;
                    n_count    = '0;
                    n_esc      = 1'b0;
                    n_xor      = 8'h00;
                end
            end else if (do_store) begin
                n_esc = 1'b0;
                if (full || (!r_esc && (r_count == COUNT_LAST))) begin
                    // Store overflow closes the frame.
                    o_res.has_result = 1'b1;
                    o_res.kind       = KIND_OVF;
                    n_in_frame       = 1'b0;
                    n_count          = '0;
                    n_xor            = 8'h00;
                end else begin
                    n_count = r_count + 1'b1;
                    n_xor   = r_xor ^ v_byte;
                end
            end else if (c == ESC_BYTE) begin
                n_esc = 1'b1;
            end else if (r_count >= COUNT_HEAD) begin
                // Closing flag of a frame that holds a full header.
                o_res.has_result = 1'b1;
                n_in_frame       = 1'b0;
                n_count          = '0;
                n_esc            = 1'b0;
                n_xor            = 8'h00;
                if (frame_ok) begin
                    o_res.kind        = KIND_OK;
                    o_res.msg_id      = {r_hdr[0], r_hdr[1]};
                    o_res.phone       = phone;
                    o_res.term_id     = term_id;
                    o_res.body_length = blen[9:0];
                end else begin
                    o_res.kind = KIND_ERR;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_xor      <= 8'h00;
        end else begin
            r_count    <= n_count;
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_xor      <= n_xor;
        end
    end

    // Shadow copy of the first header bytes as they are stored.
    always_ff @(posedge i_clk) begin
        if (wr_en && (r_count < COUNT_KEEP)) begin
            r_hdr[r_count[$clog2(HDR_KEEP)-1:0]] <= v_byte;
        end
    end

    // Frame store ports.
    assign o_wr_en   = wr_en;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = v_byte;
    assign o_rd_en   = i_accept && (i_beat.func == FUNC_READ);
    assign o_rd_addr = BODY_BASE + AW'(i_beat.body_index);

endmodule
